/* hdl/vtesc_pkg.sv */
// ----------------------------------------------------------------------------
// vtesc_pkg
// Event codes, action codes and the record passed between parser stages.
// ----------------------------------------------------------------------------
package vtesc_pkg;

    localparam int unsigned OP_W    = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACT_W   = 4;
    localparam int unsigned STATE_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_RESET   = 4'd0,
        OP_FLUSH   = 4'd1,
        OP_ESC     = 4'd2,
        OP_EXECUTE = 4'd3,
        OP_PRINT   = 4'd4,
        OP_INTER   = 4'd5,
        OP_PARAM   = 4'd6,
        OP_COLON   = 4'd7,
        OP_PRIVATE = 4'd8,
        OP_CSI     = 4'd9,
        OP_SS3     = 4'd10,
        OP_FINAL   = 4'd11
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 4'd0,
        ACT_CLEAR   = 4'd1,
        ACT_ESCD    = 4'd2,
        ACT_EXECUTE = 4'd3,
        ACT_PRINT   = 4'd4,
        ACT_COLLECT = 4'd5,
        ACT_PARAM   = 4'd6,
        ACT_CSID    = 4'd7,
        ACT_SS3D    = 4'd8
    } t_act;

    // Event held in the input register
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
    } t_evt;

    // Outcome of one event: one action, or two when pair is set
    typedef struct packed {
        t_act                first_act;
        t_act                second_act;
        logic                pair;
        logic [STATE_W-1:0]  new_state;
        logic [BYTE_W-1:0]   data_byte;
    } t_step;

endpackage

/* hdl/vtesc_if.sv */
// ----------------------------------------------------------------------------
// vtesc_if
// Valid/ready channels for parser events and parser actions.
// ----------------------------------------------------------------------------
interface vtesc_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface vtesc_act_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic [7:0] action_byte;
    logic [2:0] new_state;
    logic       last;

    modport source (output valid, output action, output action_byte,
                    output new_state, output last, input ready);
    modport sink   (input valid, input action, input action_byte,
                    input new_state, input last, output ready);
endinterface

/* hdl/vt_escape_sequence_parser_fsm.sv */
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser_fsm
// Escape-sequence parser: classified character events in, action codes out.
// ----------------------------------------------------------------------------
// One event is taken per clock while the result register is free (empty, or
// o_act ready with no second action pending); its first action reaches o_act
// via the input register, then the result register. Most events give one
// action; flush while in the escape state gives clear then esc_dispatch, and
// the second action holds the result register until taken. Every action carries
// the event's byte and the parser state after the event; last marks the final
// action of an event. The user must write input_mode through i_cfg_we/
// i_cfg_wdata only while the parser is idle; the block does not enforce it.
module vt_escape_sequence_parser_fsm (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    vtesc_evt_if.sink   i_evt,
    vtesc_act_if.source o_act
);
    import vtesc_pkg::*;

    logic  evt_valid;
    t_evt  evt;
    logic  take;
    logic  out_free;
    t_step step;

    vtesc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_take  (take),
        .o_valid (evt_valid),
        .o_evt   (evt)
    );

    vtesc_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (evt_valid),
        .i_evt       (evt),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_step      (step)
    );

    vtesc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_step  (step),
        .o_free  (out_free),
        .o_act   (o_act)
    );

endmodule

/* hdl/vtesc_in_stage.sv */
// ----------------------------------------------------------------------------
// vtesc_in_stage
// Input register: captures one event per transfer, frees as it is consumed.
// ----------------------------------------------------------------------------
module vtesc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vtesc_evt_if.sink         i_evt,
    input  logic              i_take,
    output logic              o_valid,
    output vtesc_pkg::t_evt   o_evt
);
    import vtesc_pkg::*;

    logic r_valid;
    logic n_valid;
    t_evt r_evt;

    assign i_evt.ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_evt.ready) begin
            n_valid = i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_evt.valid && i_evt.ready) begin
            r_evt.op        <= i_evt.op;
            r_evt.data_byte <= i_evt.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;

endmodule

/* hdl/vtesc_fsm.sv */
// ----------------------------------------------------------------------------
// vtesc_fsm
// Parser state, input-mode register and the per-event transition table.
// ----------------------------------------------------------------------------
module vtesc_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    input  vtesc_pkg::t_evt   i_evt,
    input  logic              i_out_free,
    output logic              o_take,
    output vtesc_pkg::t_step  o_step
);
    import vtesc_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        S_NORMAL    = 3'd0,
        S_ESCAPE    = 3'd1,
        S_ESC_IMED  = 3'd2,
        S_CSI_BEGIN = 3'd3,
        S_CSI_ARGS  = 3'd4,
        S_CSI_IMED  = 3'd5,
        S_CSI_DROP  = 3'd6,
        S_SS3       = 3'd7
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_input_mode;
    t_act   first_act;
    t_act   second_act;
    logic   pair;

    assign o_take = i_valid && i_out_free;

    always_comb begin
        n_state    = r_state;
        first_act  = ACT_NONE;
        second_act = ACT_NONE;
        pair       = 1'b0;
        unique case (t_op'(i_evt.op))
            OP_RESET: begin
                first_act = ACT_CLEAR;
                n_state   = S_NORMAL;
            end
            OP_FLUSH: begin
                first_act = ACT_CLEAR;
                if (r_state == S_ESCAPE) begin
                    second_act = ACT_ESCD;
                    pair       = 1'b1;
                end
                n_state = S_NORMAL;
            end
            OP_ESC: begin
                n_state = S_ESCAPE;
            end
            OP_EXECUTE: begin
                first_act = ACT_EXECUTE;
            end
            OP_PRINT: begin
                if (r_state == S_NORMAL) begin
                    first_act = ACT_PRINT;
                end
            end
            OP_INTER: begin
                // input mode: an intermediate right after ESC is the final
                if (r_state == S_ESCAPE && r_input_mode) begin
                    first_act = ACT_ESCD;
                    n_state   = S_NORMAL;
                end else if (r_state inside {S_ESCAPE, S_ESC_IMED}) begin
                    first_act = ACT_COLLECT;
                    n_state   = S_ESC_IMED;
                end else if (r_state inside {S_CSI_BEGIN, S_CSI_ARGS,
                                             S_CSI_IMED}) begin
                    first_act = ACT_COLLECT;
                    n_state   = S_CSI_IMED;
                end
            end
            OP_PARAM: begin
                if (r_state inside {S_CSI_BEGIN, S_CSI_ARGS}) begin
                    first_act = ACT_PARAM;
                    n_state   = S_CSI_ARGS;
                end else if (r_state inside {S_CSI_IMED, S_CSI_DROP}) begin
                    n_state = S_CSI_DROP;
                end
            end
            OP_COLON: begin
                if (r_state inside {S_CSI_BEGIN, S_CSI_ARGS, S_CSI_IMED,
                                    S_CSI_DROP}) begin
                    n_state = S_CSI_DROP;
                end
            end
            OP_PRIVATE: begin
                if (r_state == S_CSI_BEGIN) begin
                    first_act = ACT_COLLECT;
                    n_state   = S_CSI_ARGS;
                end else if (r_state inside {S_CSI_ARGS, S_CSI_IMED,
                                             S_CSI_DROP}) begin
                    n_state = S_CSI_DROP;
                end
            end
            OP_CSI: begin
                if (r_state == S_ESCAPE) begin
                    n_state = S_CSI_BEGIN;
                end
            end
            OP_SS3: begin
                if (r_state == S_ESCAPE) begin
                    n_state = S_SS3;
                end
            end
            OP_FINAL: begin
                if (r_state inside {S_ESCAPE, S_ESC_IMED}) begin
                    first_act = ACT_ESCD;
                    n_state   = S_NORMAL;
                end else if (r_state inside {S_CSI_BEGIN, S_CSI_ARGS,
                                             S_CSI_IMED}) begin
                    first_act = ACT_CSID;
                    n_state   = S_NORMAL;
                end else if (r_state == S_CSI_DROP) begin
                    n_state = S_NORMAL;
                end else if (r_state == S_SS3) begin
                    first_act = ACT_SS3D;
                    n_state   = S_NORMAL;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_NORMAL;
            r_input_mode <= 1'b0;
        end else begin
            if (o_take) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_input_mode <= i_cfg_wdata;
            end
        end
    end

    assign o_step.first_act  = first_act;
    assign o_step.second_act = second_act;
    assign o_step.pair       = pair;
    assign o_step.new_state  = n_state;
    assign o_step.data_byte  = i_evt.data_byte;

    a_reset_to_ground: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && (i_evt.op == OP_RESET || i_evt.op == OP_FLUSH)
        |=> r_state == S_NORMAL)
        else $error("reset or flush did not return to ground");

    a_pair_only_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && pair |-> i_evt.op == OP_FLUSH && r_state == S_ESCAPE)
        else $error("two actions outside flush in escape");

endmodule

/* hdl/vtesc_out_stage.sv */
// ----------------------------------------------------------------------------
// vtesc_out_stage
// Result register with a slot for the second action of a two-action event.
// ----------------------------------------------------------------------------
module vtesc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  vtesc_pkg::t_step  i_step,
    output logic              o_free,
    vtesc_act_if.source       o_act
);
    import vtesc_pkg::*;

    logic               r_valid;
    logic               r_pend;
    t_act               r_action;
    t_act               r_pend_action;
    logic               r_last;
    logic [BYTE_W-1:0]  r_byte;
    logic [STATE_W-1:0] r_state;
    logic               shift;

    // free when empty, or when the shown result is the last of its event and o_act is ready
    assign o_free = !r_valid || (o_act.ready && !r_pend);
    assign shift  = r_valid && r_pend && o_act.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
            r_pend  <= i_step.pair;
        end else if (shift) begin
            r_pend  <= 1'b0;
        end else if (o_act.ready) begin
            r_valid <= 1'b0;
        end
        if (i_take) begin
            r_action      <= i_step.first_act;
            r_pend_action <= i_step.second_act;
            r_last        <= !i_step.pair;
            r_byte        <= i_step.data_byte;
            r_state       <= i_step.new_state;
        end else if (shift) begin
            r_action <= r_pend_action;
            r_last   <= 1'b1;
        end
    end

    assign o_act.valid       = r_valid;
    assign o_act.action      = r_action;
    assign o_act.action_byte = r_byte;
    assign o_act.new_state   = r_state;
    assign o_act.last        = r_last;

    a_pend_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && !r_last)
        else $error("pending second action without a shown first");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && o_act.ready && !r_last
        |=> r_valid && r_last && r_action == ACT_ESCD)
        else $error("second action of a pair missing");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_action == ACT_CLEAR && r_pend_action == ACT_ESCD)
        else $error("action pair out of order");

endmodule

/* tb/vt_escape_sequence_parser_fsm_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser_fsm_tb
// Self-checking bench for the escape-sequence parser. Event transfers are
// mirrored into a scoreboard that tracks parser state and input_mode and
// queues the expected actions; every action transfer is checked against the
// oldest entry. Directed events come first, then mostly well-formed
// ESC/CSI/SS3 sequences with random bytes, under random stalls on both sides.
// ----------------------------------------------------------------------------
module vt_escape_sequence_parser_fsm_tb;
    import vtesc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned NUM_PHASES    = 8;

    typedef enum logic [STATE_W-1:0] {
        PS_GROUND     = 3'd0,
        PS_ESC        = 3'd1,
        PS_ESC_INT    = 3'd2,
        PS_CSI_ENTRY  = 3'd3,
        PS_CSI_PARAM  = 3'd4,
        PS_CSI_INT    = 3'd5,
        PS_CSI_IGNORE = 3'd6,
        PS_SS3        = 3'd7
    } t_parser_st;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic [BYTE_W-1:0]  abyte;
        logic [STATE_W-1:0] nstate;
        logic               lastflag;
    } t_act_rec;

    class action_scoreboard;
        t_parser_st  state;
        bit          input_mode;
        t_act_rec    expected_actions[$];
        int unsigned errors;

        function new();
            state      = PS_GROUND;
            input_mode = 1'b0;
            errors     = 0;
        endfunction

        function void set_mode(bit m);
            input_mode = m;
        endfunction

        function int pending();
            return expected_actions.size();
        endfunction

        function bit in_csi(t_parser_st s);
            return s == PS_CSI_ENTRY || s == PS_CSI_PARAM || s == PS_CSI_INT;
        endfunction

        // Advance the parser state for one event and queue its actions
        function void note_event(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b);
            t_act       acts [0:1];
            int         n;
            t_parser_st s;
            t_act_rec   rec;
            n = 0;
            s = state;
            case (op)
                OP_RESET: begin
                    acts[0] = ACT_CLEAR; n = 1;
                    s = PS_GROUND;
                end
                OP_FLUSH: begin
                    acts[0] = ACT_CLEAR; n = 1;
                    if (s == PS_ESC) begin
                        acts[1] = ACT_ESCD; n = 2;
                    end
                    s = PS_GROUND;
                end
                OP_ESC: s = PS_ESC;
                OP_EXECUTE: begin
                    acts[0] = ACT_EXECUTE; n = 1;
                end
                OP_PRINT: begin
                    if (s == PS_GROUND) begin
                        acts[0] = ACT_PRINT; n = 1;
                    end
                end
                OP_INTER: begin
                    if (s == PS_ESC && input_mode) begin
                        acts[0] = ACT_ESCD; n = 1;
                        s = PS_GROUND;
                    end else if (s == PS_ESC || s == PS_ESC_INT) begin
                        acts[0] = ACT_COLLECT; n = 1;
                        s = PS_ESC_INT;
                    end else if (in_csi(s)) begin
                        acts[0] = ACT_COLLECT; n = 1;
                        s = PS_CSI_INT;
                    end
                end
                OP_PARAM: begin
                    if (s == PS_CSI_ENTRY || s == PS_CSI_PARAM) begin
                        acts[0] = ACT_PARAM; n = 1;
                        s = PS_CSI_PARAM;
                    end else if (s == PS_CSI_INT || s == PS_CSI_IGNORE) begin
                        s = PS_CSI_IGNORE;
                    end
                end
                OP_COLON: begin
                    if (in_csi(s) || s == PS_CSI_IGNORE) s = PS_CSI_IGNORE;
                end
                OP_PRIVATE: begin
                    if (s == PS_CSI_ENTRY) begin
                        acts[0] = ACT_COLLECT; n = 1;
                        s = PS_CSI_PARAM;
                    end else if (s == PS_CSI_PARAM || s == PS_CSI_INT ||
                                 s == PS_CSI_IGNORE) begin
                        s = PS_CSI_IGNORE;
                    end
                end
                OP_CSI: begin
                    if (s == PS_ESC) s = PS_CSI_ENTRY;
                end
                OP_SS3: begin
                    if (s == PS_ESC) s = PS_SS3;
                end
                OP_FINAL: begin
                    if (s == PS_ESC || s == PS_ESC_INT) begin
                        acts[0] = ACT_ESCD; n = 1;
                        s = PS_GROUND;
                    end else if (in_csi(s)) begin
                        acts[0] = ACT_CSID; n = 1;
                        s = PS_GROUND;
                    end else if (s == PS_CSI_IGNORE) begin
                        s = PS_GROUND;
                    end else if (s == PS_SS3) begin
                        acts[0] = ACT_SS3D; n = 1;
                        s = PS_GROUND;
                    end
                end
                default: ;
            endcase
            if (n == 0) begin
                acts[0] = ACT_NONE; n = 1;
            end
            state = s;
            for (int k = 0; k < n; k++) begin
                rec.act      = acts[k];
                rec.abyte    = b;
                rec.nstate   = s;
                rec.lastflag = (k == n - 1);
                expected_actions.push_back(rec);
            end
        endfunction

        function void check_action(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] b,
                                   logic [STATE_W-1:0] st, logic lst);
            t_act_rec exp_rec;
            if (expected_actions.size() == 0) begin
                $display("%0t: unexpected action %0d byte %h state %0d last %0b",
                         $time, act, b, st, lst);
                errors++;
                return;
            end
            exp_rec = expected_actions.pop_front();
            if (act !== exp_rec.act) begin
                $display("%0t: action mismatch: expected %0d, got %0d",
                         $time, exp_rec.act, act);
                errors++;
            end
            if (b !== exp_rec.abyte) begin
                $display("%0t: action_byte mismatch: expected %h, got %h",
                         $time, exp_rec.abyte, b);
                errors++;
            end
            if (st !== exp_rec.nstate) begin
                $display("%0t: new_state mismatch: expected %0d, got %0d",
                         $time, exp_rec.nstate, st);
                errors++;
            end
            if (lst !== exp_rec.lastflag) begin
                $display("%0t: last mismatch: expected %0b, got %0b",
                         $time, exp_rec.lastflag, lst);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    vtesc_evt_if evt_if ();
    vtesc_act_if act_if ();

    vt_escape_sequence_parser_fsm u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (evt_if),
        .o_act       (act_if)
    );

    action_scoreboard sb;
    bit               steady_run;
    bit               hold_req;
    int unsigned      sent_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("vt_escape_sequence_parser_fsm regression: fail");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mirror transfers into the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.set_mode(i_cfg_wdata);
            if (evt_if.valid && evt_if.ready)
                sb.note_event(evt_if.op, evt_if.data_byte);
            if (act_if.valid && act_if.ready)
                sb.check_action(act_if.action, act_if.action_byte,
                                act_if.new_state, act_if.last);
        end
    end

    // Receiver side: random stalls, steady stretches, one long hold-off
    initial begin
        int unsigned gap;
        act_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                act_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                act_if.ready <= 1'b1;
            end else if (steady_run) begin
                act_if.ready <= 1'b1;
            end else begin
                gap = idle_len();
                if (gap == 0) begin
                    act_if.ready <= 1'b1;
                end else begin
                    act_if.ready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_evt(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = (steady_run || hold_req) ? 0 : idle_len();
        if (gap != 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_if.valid     <= 1'b1;
        evt_if.op        <= op;
        evt_if.data_byte <= b;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic logic [BYTE_W-1:0] rnd_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Parser must be idle before input_mode changes; the extra edge lets the
    // mirror note the last event transfer first
    task automatic write_mode(input bit m);
        evt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_sequence();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 4) == 0) send_evt(OP_EXECUTE, rnd_byte());
                else send_evt(OP_PRINT, rnd_byte());
            end
        end else if (r < 30) begin
            send_evt(OP_ESC, 8'h1b);
            n = $urandom_range(0, 2);
            repeat (n) send_evt(OP_INTER, rnd_byte());
            send_evt(OP_FINAL, rnd_byte());
        end else if (r < 60) begin
            send_evt(OP_ESC, 8'h1b);
            send_evt(OP_CSI, rnd_byte());
            if ($urandom_range(0, 1)) send_evt(OP_PRIVATE, rnd_byte());
            n = $urandom_range(0, 4);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: send_evt(OP_COLON, rnd_byte());
                    1: send_evt(OP_EXECUTE, rnd_byte());
                    2: send_evt(OP_PRIVATE, rnd_byte());
                    default: send_evt(OP_PARAM, rnd_byte());
                endcase
            end
            if ($urandom_range(0, 2) == 0) begin
                send_evt(OP_INTER, rnd_byte());
                if ($urandom_range(0, 3) == 0) send_evt(OP_PARAM, rnd_byte());
            end
            send_evt(OP_FINAL, rnd_byte());
        end else if (r < 68) begin
            send_evt(OP_ESC, 8'h1b);
            send_evt(OP_SS3, rnd_byte());
            if ($urandom_range(0, 3) == 0) send_evt(OP_EXECUTE, rnd_byte());
            send_evt(OP_FINAL, rnd_byte());
        end else if (r < 74) begin
            send_evt(OP_ESC, 8'h1b);
            if ($urandom_range(0, 1)) send_evt(OP_INTER, rnd_byte());
            send_evt(OP_FLUSH, rnd_byte());
        end else begin
            // noise, undefined codes included
            n = $urandom_range(1, 3);
            repeat (n) send_evt(OP_W'($urandom_range(0, 15)), rnd_byte());
        end
    endtask

    initial begin
        bit mode;
        sb              = new();
        steady_run      = 1'b0;
        hold_req        = 1'b0;
        sent_count      = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        evt_if.valid    = 1'b0;
        evt_if.op       = OP_RESET;
        evt_if.data_byte = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, input_mode at reset value
        send_evt(OP_RESET, 8'h00);
        send_evt(OP_PRINT, 8'hff);
        send_evt(OP_FINAL, 8'h41);      // final in ground: no action
        send_evt(OP_EXECUTE, 8'h07);
        send_evt(OP_FLUSH, 8'h18);      // flush in ground: clear only
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_PRINT, 8'h55);      // printable outside ground
        send_evt(OP_EXECUTE, 8'h0a);
        send_evt(OP_FLUSH, 8'haa);      // flush in escape: clear + esc_dispatch
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_INTER, 8'h20);
        send_evt(OP_INTER, 8'h2f);
        send_evt(OP_FINAL, 8'h7e);
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_CSI, 8'h5b);
        send_evt(OP_PRIVATE, 8'h3f);
        send_evt(OP_PARAM, 8'h30);
        send_evt(OP_PRIVATE, 8'h3c);    // private after params: ignore
        send_evt(OP_PARAM, 8'h39);
        send_evt(OP_FINAL, 8'h6d);      // final in ignore: silent
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_CSI, 8'h5b);
        send_evt(OP_COLON, 8'h3a);
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_SS3, 8'h4f);
        send_evt(OP_FINAL, 8'h50);
        send_evt(OP_UNDEF_LO, 8'h80);
        send_evt(OP_UNDEF_HI, 8'h01);

        write_mode(1'b1);
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_INTER, 8'h28);      // acts as final in input mode
        send_evt(OP_ESC, 8'h1b);
        send_evt(OP_CSI, 8'h5b);
        send_evt(OP_INTER, 8'h24);
        send_evt(OP_PARAM, 8'h31);
        send_evt(OP_FINAL, 8'h70);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            mode = (ph < 4) ? ph[0] : bit'($urandom_range(0, 1));
            write_mode(mode);
            steady_run = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while the sender keeps offering
            if (ph == 2) hold_req = 1'b1;
            sent_count = 0;
            while (sent_count < PHASE_ITEMS) send_sequence();
            steady_run = 1'b0;
        end

        evt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected actions never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("vt_escape_sequence_parser_fsm regression: pass");
        end else begin
            $display("vt_escape_sequence_parser_fsm regression: fail");
        end
        $finish;
    end

endmodule

/* vt_escape_sequence_parser_fsm.f */
hdl/vtesc_pkg.sv
hdl/vtesc_if.sv
hdl/vtesc_in_stage.sv
hdl/vtesc_fsm.sv
hdl/vtesc_out_stage.sv
hdl/vt_escape_sequence_parser_fsm.sv
tb/vt_escape_sequence_parser_fsm_tb.sv
